// ===== rtl/core/sbi_pkg.sv =====
package sbi_pkg;

  localparam int unsigned DATA_W = 24;
  localparam int unsigned DIFF_W = DATA_W + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned QUOT_W = DIFF_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] abscissa;
    logic signed [DATA_W-1:0] point_value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     accepted;
  } out_t;

  typedef struct packed {
    logic ins;
    logic rot;
    logic occ;
    logic first_free;
    logic last;
  } cell_ctl_t;

endpackage

// ===== rtl/core/sbi_cell.sv =====
module sbi_cell import sbi_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctl_t                ctl_i,
  input  logic signed [DATA_W-1:0] x_i,
  input  logic signed [DATA_W-1:0] p_i,
  input  logic signed [DATA_W-1:0] prev_a_i,
  input  logic signed [DATA_W-1:0] prev_p_i,
  input  logic                     prev_gt_i,
  input  logic signed [DATA_W-1:0] next_a_i,
  input  logic signed [DATA_W-1:0] next_p_i,
  input  logic signed [DATA_W-1:0] head_a_i,
  input  logic signed [DATA_W-1:0] head_p_i,
  output logic signed [DATA_W-1:0] a_o,
  output logic signed [DATA_W-1:0] p_o,
  output logic                     gt_o
);

  logic signed [DATA_W-1:0] a_q, a_d;
  logic signed [DATA_W-1:0] p_q, p_d;

  assign gt_o = ctl_i.occ && (a_q > x_i);
  assign a_o  = a_q;
  assign p_o  = p_q;

  always_comb begin
    a_d = a_q;
    p_d = p_q;
    if (ctl_i.ins) begin
      if (gt_o || ctl_i.first_free) begin
        if (prev_gt_i) begin
          a_d = prev_a_i;
          p_d = prev_p_i;
        end else begin
          a_d = x_i;
          p_d = p_i;
        end
      end
    end else if (ctl_i.rot) begin
      if (ctl_i.last) begin
        a_d = head_a_i;
        p_d = head_p_i;
      end else begin
        a_d = next_a_i;
        p_d = next_p_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    p_q <= p_d;
  end

endmodule

// ===== rtl/core/sbi_div.sv =====
module sbi_div import sbi_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [PROD_W-1:0] dividend_i,
  input  logic        [DIFF_W-1:0] divisor_i,
  output logic                     done_o,
  output logic signed [QUOT_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QUOT_W - 1);

  logic              run_q, run_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIFF_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] lo_q, lo_d;
  logic [QUOT_W-1:0] q_q, q_d;
  logic              neg_q, neg_d;
  logic [PROD_W-1:0] mag;
  logic [DIFF_W:0]   trial;
  logic [DIFF_W:0]   diff;
  logic              ge;

  always_comb begin
    mag   = dividend_i[PROD_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    trial = {rem_q, lo_q[QUOT_W-1]};
    diff  = trial - {1'b0, divisor_i};
    ge    = trial >= {1'b0, divisor_i};
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    q_d    = q_q;
    neg_d  = neg_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = mag[PROD_W-1 -: DIFF_W];
      lo_d  = mag[QUOT_W-1:0];
      q_d   = '0;
      neg_d = dividend_i[PROD_W-1];
    end else if (run_q) begin
      rem_d = ge ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
      lo_d  = {lo_q[QUOT_W-2:0], 1'b0};
      q_d   = {q_q[QUOT_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    lo_q  <= lo_d;
    q_q   <= q_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? $signed(~q_q + 1'b1) : $signed(q_q);

endmodule

// ===== rtl/core/sorted_breakpoint_interpolator.sv =====
// Insert, and a query on an empty table: the result beat is registered and shows in the cycle after acceptance.
// A query first rotates the table once through the row of cells past the head cell. A clamped
// query is answered in the multiply state; an interpolated one goes on through the multiply
// state and the load state to a one-bit-per-cycle divider.
// One query is in flight at a time; busy stays high until its result beat is shown, and inserts never raise it.
// Reset clears the entry count and the control state; stored breakpoints are not reset.
module sorted_breakpoint_interpolator import sbi_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  in_i,
  output logic done_o,
  output out_t out_o
);

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_MUL  = 5'b00100,
    S_LOAD = 5'b01000,
    S_WAIT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] step_q, step_d;
  logic done_q, done_d;
  out_t out_q, out_d;
  logic found_q, found_d;
  logic low_q, low_d;
  logic signed [DATA_W-1:0] x_q, x_d;
  logic signed [DATA_W-1:0] first_p_q, first_p_d;
  logic signed [DATA_W-1:0] prev_a_q, prev_a_d;
  logic signed [DATA_W-1:0] prev_p_q, prev_p_d;
  logic signed [DATA_W-1:0] a0_q, a0_d, a1_q, a1_d;
  logic signed [DATA_W-1:0] p0_q, p0_d, p1_q, p1_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  logic accept;
  logic do_insert;
  logic do_rotate;
  logic signed [DIFF_W-1:0] diff_p, diff_x;
  logic [DIFF_W-1:0] span;
  logic div_start, div_done;
  logic signed [QUOT_W-1:0] quot;

  logic signed [DATA_W-1:0] cell_a [MAX_ENTRIES];
  logic signed [DATA_W-1:0] cell_p [MAX_ENTRIES];
  logic                     cell_gt [MAX_ENTRIES];

  assign accept    = start && !busy;
  assign do_insert = accept && (in_i.cmd == CMD_INSERT) && (count_q != FULL);
  assign do_rotate = (state_q == S_SCAN);
  assign busy      = (state_q != S_IDLE);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.ins        = do_insert;
    assign ctl.rot        = do_rotate;
    assign ctl.occ        = (CW'(i) < count_q);
    assign ctl.first_free = (CW'(i) == count_q);
    assign ctl.last       = (CW'(i) == count_q - 1'b1);

    if (i == 0) begin : g_first
      sbi_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .x_i       (in_i.abscissa),
        .p_i       (in_i.point_value),
        .prev_a_i  (cell_a[0]),
        .prev_p_i  (cell_p[0]),
        .prev_gt_i (1'b0),
        .next_a_i  (cell_a[(MAX_ENTRIES > 1) ? 1 : 0]),
        .next_p_i  (cell_p[(MAX_ENTRIES > 1) ? 1 : 0]),
        .head_a_i  (cell_a[0]),
        .head_p_i  (cell_p[0]),
        .a_o       (cell_a[i]),
        .p_o       (cell_p[i]),
        .gt_o      (cell_gt[i])
      );
    end else if (i == MAX_ENTRIES - 1) begin : g_end
      sbi_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .x_i       (in_i.abscissa),
        .p_i       (in_i.point_value),
        .prev_a_i  (cell_a[i-1]),
        .prev_p_i  (cell_p[i-1]),
        .prev_gt_i (cell_gt[i-1]),
        .next_a_i  (cell_a[i]),
        .next_p_i  (cell_p[i]),
        .head_a_i  (cell_a[0]),
        .head_p_i  (cell_p[0]),
        .a_o       (cell_a[i]),
        .p_o       (cell_p[i]),
        .gt_o      (cell_gt[i])
      );
    end else begin : g_mid
      sbi_cell u_cell (
        .clk_i     (clk_i),
        .ctl_i     (ctl),
        .x_i       (in_i.abscissa),
        .p_i       (in_i.point_value),
        .prev_a_i  (cell_a[i-1]),
        .prev_p_i  (cell_p[i-1]),
        .prev_gt_i (cell_gt[i-1]),
        .next_a_i  (cell_a[i+1]),
        .next_p_i  (cell_p[i+1]),
        .head_a_i  (cell_a[0]),
        .head_p_i  (cell_p[0]),
        .a_o       (cell_a[i]),
        .p_o       (cell_p[i]),
        .gt_o      (cell_gt[i])
      );
    end
  end

  assign diff_p = DIFF_W'(p1_q) - DIFF_W'(p0_q);
  assign diff_x = DIFF_W'(x_q) - DIFF_W'(a0_q);
  assign span   = DIFF_W'(a1_q) - DIFF_W'(a0_q);

  assign div_start = (state_q == S_LOAD);

  sbi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    done_d    = 1'b0;
    out_d     = out_q;
    found_d   = found_q;
    low_d     = low_q;
    x_d       = x_q;
    first_p_d = first_p_q;
    prev_a_d  = prev_a_q;
    prev_p_d  = prev_p_q;
    a0_d      = a0_q;
    a1_d      = a1_q;
    p0_d      = p0_q;
    p1_d      = p1_q;
    prod_d    = prod_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.cmd == CMD_INSERT) begin
            done_d             = 1'b1;
            out_d.result_value = '0;
            out_d.accepted     = (count_q != FULL);
            if (count_q != FULL) begin
              count_d = count_q + 1'b1;
            end
          end else if (count_q == '0) begin
            done_d             = 1'b1;
            out_d.result_value = '0;
            out_d.accepted     = 1'b1;
          end else begin
            x_d     = in_i.abscissa;
            step_d  = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (step_q == '0) begin
          low_d     = (x_q <= cell_a[0]);
          first_p_d = cell_p[0];
        end else if (!found_q && (cell_a[0] >= x_q)) begin
          found_d = 1'b1;
          a0_d    = prev_a_q;
          p0_d    = prev_p_q;
          a1_d    = cell_a[0];
          p1_d    = cell_p[0];
        end
        prev_a_d = cell_a[0];
        prev_p_d = cell_p[0];
        step_d   = step_q + 1'b1;
        if (step_q == count_q - 1'b1) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (low_q) begin
          done_d             = 1'b1;
          out_d.result_value = first_p_q;
          out_d.accepted     = 1'b1;
          state_d            = S_IDLE;
        end else if (x_q >= prev_a_q) begin
          done_d             = 1'b1;
          out_d.result_value = prev_p_q;
          out_d.accepted     = 1'b1;
          state_d            = S_IDLE;
        end else begin
          prod_d  = diff_p * diff_x;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          done_d             = 1'b1;
          out_d.result_value = p0_q + quot[DATA_W-1:0];
          out_d.accepted     = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    out_q     <= out_d;
    found_q   <= found_d;
    low_q     <= low_d;
    x_q       <= x_d;
    first_p_q <= first_p_d;
    prev_a_q  <= prev_a_d;
    prev_p_q  <= prev_p_d;
    a0_q      <= a0_d;
    a1_q      <= a1_d;
    p0_q      <= p0_d;
    p1_q      <= p1_d;
    prod_q    <= prod_d;
  end

  assign done_o = done_q;
  assign out_o  = out_q;

endmodule
